>>> hdl/sem_pkg.sv
// ----------------------------------------------------------------------------
// Sobel edge magnitude package
// Shared types, constants and helpers for the controller and the datapath.
// ----------------------------------------------------------------------------
package sem_pkg;

   // Field widths fixed by the pixel format.
   localparam int CHAN_W  = 8;
   localparam int PIX_W   = 3 * CHAN_W;
   localparam int CFG_W   = 11;
   localparam int GRAD_W  = 11;
   localparam int SUM_W   = 21;
   localparam int RAD_W   = 16;
   localparam int RES_W   = 17;
   localparam int BIT_W   = 15;
   localparam int STEP_W  = 3;

   // Image width after reset.
   localparam logic [CFG_W-1:0] WIDTH_RESET = 11'd1024;

   // Largest sum of squares whose rounded root is still below saturation.
   localparam logic [SUM_W-1:0] SAT_LIMIT = 21'd65280;
   localparam logic [CHAN_W-1:0] EDGE_MAX = 8'd255;

   // Eight root steps, one result bit each.
   localparam logic [STEP_W-1:0] ROOT_LAST = 3'd7;
   localparam logic [BIT_W-1:0]  ROOT_BIT0 = 15'h4000;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic load;
      logic shift_zero;
      logic sum;
      logic sqr;
      logic root_step;
      logic round;
      logic second;
      logic advance;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic emit_first;
      logic emit_second;
   } status_type;

   // Channel k of a packed pixel: 0 red, 1 green, 2 blue.
   function automatic logic [CHAN_W-1:0] chan_of(input logic [PIX_W-1:0] p,
                                                 input logic [1:0] k);
      logic [CHAN_W-1:0] c;
      case (k)
         2'd0:    c = p[23:16];
         2'd1:    c = p[15:8];
         default: c = p[7:0];
      endcase
      return c;
   endfunction

endpackage

>>> hdl/sem_ifs.sv
// ----------------------------------------------------------------------------
// Sobel edge magnitude channel interfaces
// Pixel request channel, edge response channel and register write channel.
// ----------------------------------------------------------------------------
interface sem_req_if;
   logic       valid;
   logic       ready;
   logic       mode;
   logic [7:0] red_in;
   logic [7:0] green_in;
   logic [7:0] blue_in;
   modport source (output valid, mode, red_in, green_in, blue_in, input ready);
   modport sink   (input valid, mode, red_in, green_in, blue_in, output ready);
endinterface

interface sem_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] red_edge;
   logic [7:0] green_edge;
   logic [7:0] blue_edge;
   logic       last_of_image;
   modport source (output valid, red_edge, green_edge, blue_edge, last_of_image,
                   input ready);
   modport sink   (input valid, red_edge, green_edge, blue_edge, last_of_image,
                   output ready);
endinterface

interface sem_csr_if;
   logic        valid;
   logic        ready;
   logic [10:0] data;
   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

>>> hdl/sem_ctrl.sv
// ----------------------------------------------------------------------------
// Sobel edge magnitude controller
// Sequences capture, window load, gradient, square, root and output per word.
// ----------------------------------------------------------------------------
module sem_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   output logic               out_valid,
   input  logic               out_ready,
   input  sem_pkg::status_type status,
   output sem_pkg::cmd_type   cmd
);

   typedef enum logic [8:0] {
      S_IDLE = 9'b000000001,
      S_LOAD = 9'b000000010,
      S_ZERO = 9'b000000100,
      S_SUM  = 9'b000001000,
      S_SQR  = 9'b000010000,
      S_ROOT = 9'b000100000,
      S_RND  = 9'b001000000,
      S_OUT  = 9'b010000000,
      S_FIN  = 9'b100000000
   } state_type;

   state_type                     state_ff, state_in;
   logic [sem_pkg::STEP_W-1:0]    step_ff, step_in;
   logic                          second_ff, second_in;

   assign in_ready  = (state_ff == S_IDLE);
   assign out_valid = (state_ff == S_OUT);

   // Next state and commands.
   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      second_in = second_ff;
      cmd       = '0;
      cmd.second = second_ff;
      case (state_ff)
         S_IDLE: begin
            if (in_valid) begin
               cmd.capture = 1'b1;
               second_in   = 1'b0;
               state_in    = S_LOAD;
            end
         end
         S_LOAD: begin
            cmd.load = 1'b1;
            if (status.emit_first) begin
               state_in = S_SUM;
            end else if (status.emit_second) begin
               state_in = S_ZERO;
            end else begin
               state_in = S_FIN;
            end
         end
         S_ZERO: begin
            cmd.shift_zero = 1'b1;
            second_in      = 1'b1;
            state_in       = S_SUM;
         end
         S_SUM: begin
            cmd.sum  = 1'b1;
            state_in = S_SQR;
         end
         S_SQR: begin
            cmd.sqr  = 1'b1;
            step_in  = '0;
            state_in = S_ROOT;
         end
         S_ROOT: begin
            cmd.root_step = 1'b1;
            step_in       = step_ff + sem_pkg::STEP_W'(1);
            if (step_ff == sem_pkg::ROOT_LAST) begin
               state_in = S_RND;
            end
         end
         S_RND: begin
            cmd.round = 1'b1;
            state_in  = S_OUT;
         end
         S_OUT: begin
            if (out_ready) begin
               if (!second_ff && status.emit_second) begin
                  state_in = S_ZERO;
               end else begin
                  state_in = S_FIN;
               end
            end
         end
         S_FIN: begin
            cmd.advance = 1'b1;
            state_in    = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         step_ff   <= '0;
         second_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         step_ff   <= step_in;
         second_ff <= second_in;
      end
   end

`ifndef SYNTHESIS
   // A word is never offered while a new pixel may be taken.
   assert property (@(posedge clock) disable iff (reset) out_valid |-> !in_ready)
      else $error("response offered while request side is open");

   // An accepted pixel always goes straight to the window load.
   assert property (@(posedge clock) disable iff (reset)
      (in_valid && in_ready) |=> (state_ff == S_LOAD))
      else $error("accepted pixel not loaded");

   // The root unit always runs its full eight steps before rounding.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RND) |-> ($past(step_ff) == sem_pkg::ROOT_LAST))
      else $error("root stopped early");

   // The second row-end word only follows a zero column shift.
   assert property (@(posedge clock) disable iff (reset)
      $rose(second_ff) |-> ($past(state_ff) == S_ZERO))
      else $error("second word without zero shift");
`endif

endmodule

>>> hdl/sem_datapath.sv
// ----------------------------------------------------------------------------
// Sobel edge magnitude datapath
// Row stores, 3x3 window, gradient sums, squares and a bit-serial square root.
// ----------------------------------------------------------------------------
module sem_datapath #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                        clock,
   input  logic                        reset,
   input  sem_pkg::cmd_type            cmd,
   output sem_pkg::status_type         status,
   input  logic                        cfg_write,
   input  logic [sem_pkg::CFG_W-1:0]   cfg_data,
   input  logic                        in_mode,
   input  logic [sem_pkg::PIX_W-1:0]   in_pix,
   output logic [sem_pkg::CHAN_W-1:0]  out_red,
   output logic [sem_pkg::CHAN_W-1:0]  out_green,
   output logic [sem_pkg::CHAN_W-1:0]  out_blue,
   output logic                        out_last
);

   localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int CW = (AW + 1 > sem_pkg::CFG_W) ? AW + 1 : sem_pkg::CFG_W;

   typedef logic [sem_pkg::PIX_W-1:0]  pix_type;
   typedef logic signed [sem_pkg::GRAD_W-1:0] grad_type;

   // Configuration and position state.
   logic [sem_pkg::CFG_W-1:0] width_ff;
   logic [AW-1:0]             col_ff;
   logic [1:0]                rows_ff;

   // Captured item and store read data.
   logic    mode_ff;
   pix_type pix_ff;
   pix_type up_rd_ff, mid_rd_ff;
   logic    emit1_ff, emit2_ff, row_end_ff;

   pix_type upper_mem [MAX_WIDTH];
   pix_type middle_mem [MAX_WIDTH];

   pix_type win_ff [9];
   pix_type win_in [9];

   grad_type gx_ff [3], gy_ff [3];
   logic [sem_pkg::RAD_W-1:0] x_ff [3];
   logic [sem_pkg::RES_W-1:0] res_ff [3];
   logic                      sat_ff [3];
   logic [sem_pkg::BIT_W-1:0] bit_ff;
   logic [sem_pkg::CHAN_W-1:0] edge_ff [3];
   logic                       last_ff;

   logic [CW-1:0] w_ext, w_eff;
   logic          row_end;
   pix_type       up_v, mid_v;

   // Effective width: zero acts as one, oversize acts as the store depth.
   assign w_ext = CW'(width_ff);
   always_comb begin
      if (w_ext == '0) begin
         w_eff = CW'(1);
      end else if (w_ext > CW'(MAX_WIDTH)) begin
         w_eff = CW'(MAX_WIDTH);
      end else begin
         w_eff = w_ext;
      end
   end
   assign row_end = (CW'(col_ff) + CW'(1)) >= w_eff;

   assign up_v  = (rows_ff >= 2'd2) ? up_rd_ff : '0;
   assign mid_v = (rows_ff >= 2'd1) ? mid_rd_ff : '0;

   assign status.emit_first  = emit1_ff;
   assign status.emit_second = emit2_ff;

   // Configuration register and row position.
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= sem_pkg::WIDTH_RESET;
         col_ff   <= '0;
         rows_ff  <= '0;
      end else begin
         if (cfg_write) begin
            width_ff <= cfg_data;
         end
         if (cmd.advance) begin
            if (row_end_ff) begin
               col_ff <= '0;
               if (mode_ff) begin
                  rows_ff <= '0;
               end else if (rows_ff != 2'd2) begin
                  rows_ff <= rows_ff + 2'd1;
               end
            end else begin
               col_ff <= col_ff + AW'(1);
            end
         end
      end
   end

   // Capture of the item, its flags and the store read.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff    <= in_mode;
         pix_ff     <= in_mode ? '0 : in_pix;
         row_end_ff <= row_end;
         emit1_ff   <= (rows_ff != 2'd0) && (col_ff != '0);
         emit2_ff   <= (rows_ff != 2'd0) && row_end;
         up_rd_ff   <= upper_mem[col_ff];
         mid_rd_ff  <= middle_mem[col_ff];
      end
   end

   // Row store writes.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         upper_mem[col_ff]  <= mid_v;
         middle_mem[col_ff] <= pix_ff;
      end
   end

   // Window shift: a new column, or a zero column after the row end.
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         win_in[r*3]   = win_ff[r*3+1];
         win_in[r*3+1] = win_ff[r*3+2];
         win_in[r*3+2] = '0;
      end
      if (cmd.load) begin
         if (col_ff == '0) begin
            for (int r = 0; r < 3; r++) begin
               win_in[r*3]   = '0;
               win_in[r*3+1] = '0;
            end
         end
         win_in[2] = up_v;
         win_in[5] = mid_v;
         win_in[8] = pix_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 9; i++) begin
            win_ff[i] <= '0;
         end
      end else if (cmd.load || cmd.shift_zero) begin
         for (int i = 0; i < 9; i++) begin
            win_ff[i] <= win_in[i];
         end
      end
   end

   // Gradient sums, one lane per channel.
   always_ff @(posedge clock) begin
      grad_type a [9];
      if (cmd.sum) begin
         for (int k = 0; k < 3; k++) begin
            for (int i = 0; i < 9; i++) begin
               a[i] = $signed({3'b000, sem_pkg::chan_of(win_ff[i], 2'(k))});
            end
            gx_ff[k] <= (a[2] + (a[5] <<< 1) + a[8]) - (a[0] + (a[3] <<< 1) + a[6]);
            gy_ff[k] <= (a[6] + (a[7] <<< 1) + a[8]) - (a[0] + (a[1] <<< 1) + a[2]);
         end
      end
   end

   // Squares and root steps; the remainder is kept for rounding.
   always_ff @(posedge clock) begin
      logic signed [2*sem_pkg::GRAD_W-1:0] px, py;
      logic [sem_pkg::SUM_W-1:0]           s;
      logic [sem_pkg::RES_W-1:0]           trial;
      if (cmd.sqr) begin
         bit_ff <= sem_pkg::ROOT_BIT0;
         for (int k = 0; k < 3; k++) begin
            px = gx_ff[k] * gx_ff[k];
            py = gy_ff[k] * gy_ff[k];
            s  = px[sem_pkg::SUM_W-1:0] + py[sem_pkg::SUM_W-1:0];
            sat_ff[k] <= s > sem_pkg::SAT_LIMIT;
            x_ff[k]   <= s[sem_pkg::RAD_W-1:0];
            res_ff[k] <= '0;
         end
      end else if (cmd.root_step) begin
         bit_ff <= bit_ff >> 2;
         for (int k = 0; k < 3; k++) begin
            trial = res_ff[k] + sem_pkg::RES_W'(bit_ff);
            if (sem_pkg::RES_W'(x_ff[k]) >= trial) begin
               x_ff[k]   <= x_ff[k] - trial[sem_pkg::RAD_W-1:0];
               res_ff[k] <= (res_ff[k] >> 1) + sem_pkg::RES_W'(bit_ff);
            end else begin
               res_ff[k] <= res_ff[k] >> 1;
            end
         end
      end
   end

   // Rounding and saturation into the output word.
   always_ff @(posedge clock) begin
      if (cmd.round) begin
         last_ff <= cmd.second && mode_ff;
         for (int k = 0; k < 3; k++) begin
            if (sat_ff[k]) begin
               edge_ff[k] <= sem_pkg::EDGE_MAX;
            end else begin
               edge_ff[k] <= res_ff[k][sem_pkg::CHAN_W-1:0]
                  + sem_pkg::CHAN_W'(sem_pkg::RES_W'(x_ff[k]) > res_ff[k]);
            end
         end
      end
   end

   assign out_red   = edge_ff[0];
   assign out_green = edge_ff[1];
   assign out_blue  = edge_ff[2];
   assign out_last  = last_ff;

endmodule

>>> hdl/sobel_edge_magnitude.sv
// Sobel edge magnitude for RGB pixels in raster order. Each accepted pixel
// yields the edge word of the pixel one row up and one column left, and a
// second word at the end of a row; after the last image row send one row of
// flush words. A new pixel is taken only after the words of the last one
// have been accepted on the response side; each output word runs the
// eight-step bit-serial square root.
// ----------------------------------------------------------------------------
// Sobel edge magnitude top level
// Joins the controller and the datapath to the request, response and
// register channels.
// ----------------------------------------------------------------------------
module sobel_edge_magnitude #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic      clock,
   input  logic      reset,
   sem_req_if.sink   req_if,
   sem_rsp_if.source rsp_if,
   sem_csr_if.sink   csr_if
);

   sem_pkg::cmd_type    cmd;
   sem_pkg::status_type status;

   // Register writes are always taken.
   assign csr_if.ready = 1'b1;

   sem_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_if.valid),
      .in_ready  (req_if.ready),
      .out_valid (rsp_if.valid),
      .out_ready (rsp_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   sem_datapath #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .cfg_write (csr_if.valid),
      .cfg_data  (csr_if.data),
      .in_mode   (req_if.mode),
      .in_pix    ({req_if.red_in, req_if.green_in, req_if.blue_in}),
      .out_red   (rsp_if.red_edge),
      .out_green (rsp_if.green_edge),
      .out_blue  (rsp_if.blue_edge),
      .out_last  (rsp_if.last_of_image)
   );

endmodule

>>> sim/sem_scoreboard.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sobel edge magnitude scoreboard
// Predicts the edge words for each accepted pixel word and checks the
// response words against them in order.
// ----------------------------------------------------------------------------
package sem_tb_pkg;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       last;
   } edge_word_type;

   class edge_scoreboard;
      logic [23:0] upper_row [1024];
      logic [23:0] middle_row [1024];
      logic [23:0] win [9];
      int unsigned column;
      int unsigned rows_done;
      logic [10:0] width_reg;
      edge_word_type pending [$];
      int unsigned errors;
      int unsigned checked;

      function new();
         clear();
         errors  = 0;
         checked = 0;
      endfunction

      function void clear();
         foreach (win[i]) win[i] = '0;
         foreach (upper_row[i]) upper_row[i] = '0;
         foreach (middle_row[i]) middle_row[i] = '0;
         column    = 0;
         rows_done = 0;
         width_reg = 11'd1024;
      endfunction

      function void set_width(logic [10:0] w);
         width_reg = w;
      endfunction

      // Exact rounded magnitude of one channel, saturated to 255.
      function logic [7:0] magnitude(int k);
         int gx, gy, v, q;
         int unsigned s;
         int kx [9] = '{-1, 0, 1, -2, 0, 2, -1, 0, 1};
         int ky [9] = '{-1, -2, -1, 0, 0, 0, 1, 2, 1};
         gx = 0;
         gy = 0;
         for (int i = 0; i < 9; i++) begin
            v  = (win[i] >> (16 - 8 * k)) & 8'hFF;
            gx += v * kx[i];
            gy += v * ky[i];
         end
         s = gx * gx + gy * gy;
         q = 0;
         while ((q + 1) * (q + 1) <= s) q++;
         if (s > q * q + q) q++;
         return (q > 255) ? 8'd255 : q[7:0];
      endfunction

      function void shift_column(logic [23:0] t, logic [23:0] m, logic [23:0] b);
         logic [23:0] c [3];
         c = '{t, m, b};
         for (int r = 0; r < 3; r++) begin
            win[r*3]   = win[r*3+1];
            win[r*3+1] = win[r*3+2];
            win[r*3+2] = c[r];
         end
      endfunction

      function void push_edge(logic last);
         edge_word_type e;
         e.red   = magnitude(0);
         e.green = magnitude(1);
         e.blue  = magnitude(2);
         e.last  = last;
         pending.push_back(e);
      endfunction

      // Notes one accepted pixel word and queues the edge words it causes.
      function void note_pixel(logic mode, logic [7:0] r, logic [7:0] g, logic [7:0] b);
         logic [23:0] pix, up, mid;
         int unsigned w, c;
         bit active, row_end;
         pix = mode ? 24'd0 : {r, g, b};
         w = width_reg;
         if (w == 0) w = 1;
         if (w > 1024) w = 1024;
         c = (column >= 1024) ? 1023 : column;
         row_end = (c + 1 >= w);
         active  = rows_done >= 1;
         up  = (rows_done >= 2) ? upper_row[c] : 24'd0;
         mid = (rows_done >= 1) ? middle_row[c] : 24'd0;
         if (c == 0) foreach (win[i]) win[i] = '0;
         shift_column(up, mid, pix);
         upper_row[c]  = mid;
         middle_row[c] = pix;
         if (active && c >= 1) push_edge(1'b0);
         if (row_end) begin
            if (active) begin
               shift_column('0, '0, '0);
               push_edge(mode);
            end
            column = 0;
            if (mode) rows_done = 0;
            else if (rows_done < 2) rows_done++;
         end else begin
            column = c + 1;
         end
      endfunction

      // Checks one response word against the oldest expected edge word.
      function void check_edge(edge_word_type got);
         edge_word_type exp;
         if (pending.size() == 0) begin
            $display("%0t: unexpected edge word %h", $time, got);
            errors++;
            return;
         end
         exp = pending.pop_front();
         checked++;
         if (got.red !== exp.red)
            $display("%0t: red expected %0d actual %0d", $time, exp.red, got.red);
         if (got.green !== exp.green)
            $display("%0t: green expected %0d actual %0d", $time, exp.green, got.green);
         if (got.blue !== exp.blue)
            $display("%0t: blue expected %0d actual %0d", $time, exp.blue, got.blue);
         if (got.last !== exp.last)
            $display("%0t: last expected %0b actual %0b", $time, exp.last, got.last);
         if (got !== exp) errors++;
      endfunction
   endclass

endpackage

>>> sim/sobel_edge_magnitude_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sobel edge magnitude testbench
// Streams images of several widths with random gaps and stalls, and checks
// every edge word against a scoreboard prediction.
// ----------------------------------------------------------------------------
module sobel_edge_magnitude_tb;

   logic clock;
   logic reset;

   sem_req_if req_if ();
   sem_rsp_if rsp_if ();
   sem_csr_if csr_if ();

   sobel_edge_magnitude u_top (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if.sink),
      .rsp_if (rsp_if.source),
      .csr_if (csr_if.sink)
   );

   sem_tb_pkg::edge_scoreboard board;
   bit quiet;        // no idling in the last part of the run
   bit long_hold;    // receiver holds off for a long stretch
   int unsigned pixels_sent;
   int unsigned idle_cycles;
   int unsigned images_done;

   localparam int unsigned WATCHDOG_LIMIT = 40000;

   // Clock.
   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   // Receiver: random stall bursts, and one long hold-off on request.
   initial begin
      int n;
      rsp_if.ready = 1'b0;
      @(posedge clock);
      forever begin
         if (long_hold) begin
            rsp_if.ready <= 1'b0;
            repeat (400) @(posedge clock);
            long_hold = 1'b0;
         end else if (!quiet && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 15);
            rsp_if.ready <= 1'b0;
            repeat (n) @(posedge clock);
         end else begin
            n = $urandom_range(1, 20);
            rsp_if.ready <= 1'b1;
            repeat (n) @(posedge clock);
         end
      end
   end

   // Result monitor and watchdog.
   always @(posedge clock) begin
      sem_tb_pkg::edge_word_type got;
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            got = '{rsp_if.red_edge, rsp_if.green_edge, rsp_if.blue_edge,
                    rsp_if.last_of_image};
            board.check_edge(got);
         end
         if ((rsp_if.valid && rsp_if.ready) || (req_if.valid && req_if.ready) ||
             (csr_if.valid && csr_if.ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired", $time);
            $display("sobel_edge_magnitude: mismatch");
            $finish;
         end
      end
   end

   // Sends one pixel word, with an optional random gap before it. Valid
   // stays high after the accepting edge until the next word or an idle.
   task automatic send_pixel(logic mode, logic [7:0] r, logic [7:0] g, logic [7:0] b);
      if (!quiet && $urandom_range(0, 7) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_if.valid    <= 1'b1;
      req_if.mode     <= mode;
      req_if.red_in   <= r;
      req_if.green_in <= g;
      req_if.blue_in  <= b;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      board.note_pixel(mode, r, g, b);
      pixels_sent++;
   endtask

   // Waits for the block to drain, then writes the width register.
   task automatic write_width(logic [10:0] w);
      int guard;
      req_if.valid <= 1'b0;
      guard = 0;
      while (board.pending.size() != 0 && guard < 200000) begin
         @(posedge clock);
         guard++;
      end
      repeat (40) @(posedge clock);
      csr_if.valid <= 1'b1;
      csr_if.data  <= w;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      csr_if.valid <= 1'b0;
      board.set_width(w);
   endtask

   // One image: rows of pixels in a chosen pattern, then a flush row.
   task automatic send_image(int unsigned w, int unsigned rows, int pattern);
      logic [7:0] r, g, b;
      int unsigned ew;
      ew = (w == 0) ? 1 : (w > 1024 ? 1024 : w);
      for (int unsigned y = 0; y < rows; y++) begin
         for (int unsigned x = 0; x < ew; x++) begin
            case (pattern)
               0: {r, g, b} = {3{((x + y) % 2) ? 8'hFF : 8'h00}};
               1: {r, g, b} = {8'hFF, 8'h00, (x % 2) ? 8'hFF : 8'h00};
               default: {r, g, b} = 24'($urandom());
            endcase
            // A flush word mixed into a row now and then.
            send_pixel((pattern > 1 && $urandom_range(0, 40) == 0), r, g, b);
         end
      end
      for (int unsigned x = 0; x < ew; x++)
         send_pixel(1'b1, 8'($urandom()), 8'($urandom()), 8'($urandom()));
      images_done++;
   endtask

   initial begin
      int unsigned w;
      board = new();
      quiet = 1'b0;
      long_hold = 1'b0;
      pixels_sent = 0;
      idle_cycles = 0;
      images_done = 0;
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.mode = 1'b0;
      req_if.red_in = '0;
      req_if.green_in = '0;
      req_if.blue_in = '0;
      csr_if.valid = 1'b0;
      csr_if.data = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: flush with nothing pending, then narrow extremes.
      write_width(11'd4);
      send_pixel(1'b1, 8'hFF, 8'hFF, 8'hFF);
      send_pixel(1'b1, 8'h00, 8'h00, 8'h00);
      send_pixel(1'b1, 8'hAA, 8'h55, 8'hAA);
      send_pixel(1'b1, 8'h55, 8'hAA, 8'h55);
      send_image(4, 2, 0);
      write_width(11'd0);
      send_image(0, 3, 1);
      write_width(11'd1);
      send_image(1, 2, 2);
      // An oversize width: one full-depth row, then a short flush row that
      // only gives words if that row ended at the store depth.
      write_width(11'd2047);
      for (int unsigned x = 0; x < 1024; x++)
         send_pixel(1'b0, 8'(x), 8'(x >> 2), 8'((x * 7) & 8'hFF));
      write_width(11'd2);
      send_pixel(1'b1, 8'h00, 8'h00, 8'h00);
      send_pixel(1'b1, 8'h00, 8'h00, 8'h00);
      images_done++;
      // A row ended early by a flush word, then a proper image.
      write_width(11'd3);
      send_pixel(1'b0, 8'hFF, 8'hFF, 8'hFF);
      send_pixel(1'b0, 8'h00, 8'hFF, 8'h00);
      send_pixel(1'b1, 8'h00, 8'h00, 8'h00);

      // Long receiver hold-off while the sender keeps offering.
      long_hold = 1'b1;
      send_image(3, 6, 2);

      // Random images of small widths, a few wider ones.
      while (pixels_sent < 1650) begin
         w = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 64) : $urandom_range(1, 12);
         if (pixels_sent > 1450) quiet = 1'b1;
         write_width(w[10:0]);
         send_image(w, $urandom_range(1, 6), 2);
      end

      // Drain and settle.
      req_if.valid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      $display("Sent %0d pixel words in %0d images; %0d edge words checked.",
               pixels_sent, images_done, board.checked);
      $display("Widths ranged from the clamped zero to the full row store.");
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("sobel_edge_magnitude: match");
      end else begin
         $display("sobel_edge_magnitude: mismatch");
      end
      $finish;
   end

endmodule

>>> sim.f
hdl/sem_pkg.sv
hdl/sem_ifs.sv
hdl/sem_ctrl.sv
hdl/sem_datapath.sv
hdl/sobel_edge_magnitude.sv
sim/sem_scoreboard.sv
sim/sobel_edge_magnitude_tb.sv
